>>> rtl/core/c39_pkg.sv
// ----------------------------------------------------------------------------
// c39_pkg
// Shared types, constants and the symbol pattern table of the bar run
// generator.
// ----------------------------------------------------------------------------
package c39_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam int unsigned CharW   = 8;
  localparam int unsigned PatW    = 9;
  localparam int unsigned PixW    = 16;
  localparam int unsigned LenW    = 12;
  localparam int unsigned NarrowW = 8;
  localparam int unsigned WideW   = 10;
  localparam int unsigned GapW    = 8;
  localparam int unsigned ElemW   = $clog2(PatW);
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned OutDataW = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMargin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNarrow = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWide   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGap    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLight  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDark   = 3'd5;

  // pattern literals: leftmost bit is the first (dark) element, 1 = wide
  localparam logic [PatW-1:0] StarPattern  = 9'b010010100;
  localparam logic [PatW-1:0] SpacePattern = 9'b011000100;

  typedef struct packed {
    logic [LenW-1:0]    margin;
    logic [NarrowW-1:0] narrow;
    logic [WideW-1:0]   wide;
    logic [GapW-1:0]    gap;
    logic [PixW-1:0]    light;
    logic [PixW-1:0]    dark;
  } cfg_t;

  typedef struct packed {
    logic [PatW-1:0] pattern;
    logic            first;
    logic            last;
  } job_t;

  function automatic logic [PatW-1:0] char_pattern(input logic [CharW-1:0] c);
    logic [CharW-1:0] u;
    logic [PatW-1:0]  p;
    u = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      u = c - 8'h20;
    end
    case (u)
      8'h24: p = 9'b010101000;
      8'h25: p = 9'b000101010;
      8'h2a: p = StarPattern;
      8'h2b: p = 9'b010001010;
      8'h7c: p = 9'b010000101;
      8'h2d: p = 9'b010000101;
      8'h2e: p = 9'b110000100;
      8'h2f: p = 9'b010100010;
      8'h30: p = 9'b000110100;
      8'h31: p = 9'b100100001;
      8'h32: p = 9'b001100001;
      8'h33: p = 9'b101100000;
      8'h34: p = 9'b000110001;
      8'h35: p = 9'b100110000;
      8'h36: p = 9'b001110000;
      8'h37: p = 9'b000100101;
      8'h38: p = 9'b100100100;
      8'h39: p = 9'b001100100;
      8'h41: p = 9'b100001001;
      8'h42: p = 9'b001001001;
      8'h43: p = 9'b101001000;
      8'h44: p = 9'b000011001;
      8'h45: p = 9'b100011000;
      8'h46: p = 9'b001011000;
      8'h47: p = 9'b000001101;
      8'h48: p = 9'b100001100;
      8'h49: p = 9'b001001100;
      8'h4a: p = 9'b000011100;
      8'h4b: p = 9'b100000011;
      8'h4c: p = 9'b001000011;
      8'h4d: p = 9'b101000010;
      8'h4e: p = 9'b000010011;
      8'h4f: p = 9'b100010010;
      8'h50: p = 9'b001010010;
      8'h51: p = 9'b000000111;
      8'h52: p = 9'b100000110;
      8'h53: p = 9'b001000110;
      8'h54: p = 9'b000010110;
      8'h55: p = 9'b110000001;
      8'h56: p = 9'b011000001;
      8'h57: p = 9'b111000000;
      8'h58: p = 9'b010010001;
      8'h59: p = 9'b110010000;
      8'h5a: p = 9'b011010000;
      default: p = SpacePattern;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/c39_front.sv
// ----------------------------------------------------------------------------
// c39_front
// Input side: accept a character transaction, look up its symbol pattern and
// queue the job for the run sequencer.
// ----------------------------------------------------------------------------
module c39_front (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [c39_pkg::CharW-1:0]     s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output c39_pkg::job_t                 q_job_o
);

  assign s_axis_tready     = !q_full_i;
  assign q_push_o          = s_axis_tvalid && !q_full_i;
  assign q_job_o.pattern   = c39_pkg::char_pattern(s_axis_tdata);
  assign q_job_o.first     = s_axis_tuser;
  assign q_job_o.last      = s_axis_tlast;

endmodule

>>> rtl/core/c39_fifo.sv
// ----------------------------------------------------------------------------
// c39_fifo
// Short job queue between the input side and the run sequencer.
// ----------------------------------------------------------------------------
module c39_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  c39_pkg::job_t wr_job_i,
  input  logic          pop_i,
  output c39_pkg::job_t rd_job_o,
  output logic          full_o,
  output logic          empty_o
);

  c39_pkg::job_t                 mem_q [c39_pkg::QDepth];
  logic [c39_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [c39_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [c39_pkg::QPtrW:0]       count_q, count_d;
  logic                          do_push, do_pop;

  assign full_o   = (count_q == (c39_pkg::QPtrW+1)'(c39_pkg::QDepth));
  assign empty_o  = (count_q == '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == (c39_pkg::QPtrW)'(c39_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == (c39_pkg::QPtrW)'(c39_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

>>> rtl/core/c39_back.sv
// ----------------------------------------------------------------------------
// c39_back
// Run sequencer: take a job from the queue and emit its bar runs, one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module c39_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  c39_pkg::cfg_t                    cfg_i,
  input  logic                             q_empty_i,
  input  c39_pkg::job_t                    q_job_i,
  output logic                             q_pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [c39_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                             m_axis_tlast
);

  typedef enum logic [2:0] {
    PhIdle,
    PhMarginHead,
    PhStart,
    PhGapHead,
    PhChar,
    PhGap,
    PhStop,
    PhMarginTail
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [c39_pkg::ElemW-1:0]       elem_q, elem_d;
  logic [c39_pkg::PatW-1:0]        pat_q;
  logic                            last_q;
  logic                            m_valid_q;
  logic [c39_pkg::PixW-1:0]        pix_q, pix_d;
  logic [c39_pkg::LenW-1:0]        len_q, len_d;
  logic                            eob_q, eob_d;
  logic                            out_free;
  logic                            emit;
  logic                            elem_done;
  logic                            wide_bit;
  logic [c39_pkg::PatW-1:0]        cur_pat;
  logic [c39_pkg::ElemW-1:0]       bit_idx;
  logic [c39_pkg::LenW-1:0]        elem_len;
  logic [c39_pkg::PixW-1:0]        elem_pix;

  assign out_free  = !m_valid_q || m_axis_tready;
  assign emit      = (phase_q != PhIdle);
  assign q_pop_o   = (phase_q == PhIdle) && !q_empty_i;
  assign elem_done = (elem_q == (c39_pkg::ElemW)'(c39_pkg::PatW - 1));
  assign cur_pat   = (phase_q == PhChar) ? pat_q : c39_pkg::StarPattern;
  assign bit_idx   = (c39_pkg::ElemW)'(c39_pkg::PatW - 1) - elem_q;
  assign wide_bit  = cur_pat[bit_idx];
  assign elem_len  = wide_bit ? {2'b00, cfg_i.wide} : {4'h0, cfg_i.narrow};
  assign elem_pix  = elem_q[0] ? cfg_i.light : cfg_i.dark;

  always_comb begin
    phase_d = phase_q;
    elem_d  = elem_q;
    pix_d   = cfg_i.light;
    len_d   = elem_len;
    eob_d   = 1'b0;
    case (phase_q)
      PhIdle: begin
        len_d = '0;
      end
      PhMarginHead: begin
        len_d   = cfg_i.margin;
        phase_d = PhStart;
        elem_d  = '0;
      end
      PhStart, PhChar, PhStop: begin
        pix_d  = elem_pix;
        elem_d = elem_q + 1'b1;
        if (elem_done) begin
          elem_d = '0;
          case (phase_q)
            PhStart: phase_d = PhGapHead;
            PhChar:  phase_d = PhGap;
            default: phase_d = PhMarginTail;
          endcase
        end
      end
      PhGapHead: begin
        len_d   = {4'h0, cfg_i.gap};
        phase_d = PhChar;
        elem_d  = '0;
      end
      PhGap: begin
        len_d   = {4'h0, cfg_i.gap};
        eob_d   = !last_q;
        phase_d = last_q ? PhStop : PhIdle;
        elem_d  = '0;
      end
      PhMarginTail: begin
        len_d   = cfg_i.margin;
        eob_d   = 1'b1;
        phase_d = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elem_q    <= '0;
      m_valid_q <= 1'b0;
      eob_q     <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q <= q_job_i.first ? PhMarginHead : PhChar;
        elem_q  <= '0;
      end else if (emit && out_free) begin
        phase_q <= phase_d;
        elem_q  <= elem_d;
      end
      if (out_free) begin
        m_valid_q <= emit;
        eob_q     <= eob_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pat_q  <= q_job_i.pattern;
      last_q <= q_job_i.last;
    end
    if (out_free) begin
      pix_q <= pix_d;
      len_q <= len_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'h0, len_q, pix_q};
  assign m_axis_tlast  = eob_q;

  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_q <= (c39_pkg::ElemW)'(c39_pkg::PatW - 1))
    else $error("element counter out of range");

  a_gap_to_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhGapHead && out_free) |=> (phase_q == PhChar && elem_q == '0))
    else $error("leading gap not followed by the character symbol");

  a_tail_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhMarginTail && out_free) |=> (m_valid_q && eob_q && phase_q == PhIdle))
    else $error("trailing quiet zone not marked as burst end");

  a_stall_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhIdle && !out_free) |=> $stable(phase_q) && $stable(elem_q))
    else $error("sequencer advanced while output stalled");

endmodule

>>> rtl/core/code39_bar_run_generator_core.sv
// ----------------------------------------------------------------------------
// code39_bar_run_generator_core
// Code 39 bar run generator: one character in, its bar runs out.
// ----------------------------------------------------------------------------
// Input channel s_axis: one character per transaction, tuser flags the first
// character of a line (quiet zone, start symbol and gap in front), tlast the
// last one (stop symbol and quiet zone behind its gap).
// Output channel m_axis: one bar run per transaction, pixel value and run
// length in tdata, tlast on the final run of each input character.
// Configuration: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is
// high; write only while the block is idle.
// Throughput: the sequencer emits one run per cycle while the output is not
// stalled, and fetches each job from the two-entry queue in an idle state in
// which no run is emitted. An accepted character passes through the queue,
// the phase register and the output register before its first run appears.
// A stalled receiver holds the output register and the sequencer; the queue
// keeps taking characters until it is full.
// Reset clears the queue and sequencer and loads the register defaults.
// ----------------------------------------------------------------------------
module code39_bar_run_generator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [c39_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [c39_pkg::CfgW-1:0]          cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [c39_pkg::CharW-1:0]         s_axis_tdata,  // [7:0] char_code
  input  logic                              s_axis_tuser,  // [0] is_first
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [c39_pkg::OutDataW-1:0]      m_axis_tdata,  // [15:0] pixel_value,
                                                           // [27:16] run_length
  output logic                              m_axis_tlast
);

  c39_pkg::cfg_t cfg_q;
  c39_pkg::job_t push_job;
  c39_pkg::job_t head_job;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin <= 12'd200;
      cfg_q.narrow <= 8'd8;
      cfg_q.wide   <= 10'd16;
      cfg_q.gap    <= 8'd8;
      cfg_q.light  <= 16'd4095;
      cfg_q.dark   <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c39_pkg::CfgMargin: cfg_q.margin <= cfg_wdata_i[c39_pkg::LenW-1:0];
        c39_pkg::CfgNarrow: cfg_q.narrow <= cfg_wdata_i[c39_pkg::NarrowW-1:0];
        c39_pkg::CfgWide:   cfg_q.wide   <= cfg_wdata_i[c39_pkg::WideW-1:0];
        c39_pkg::CfgGap:    cfg_q.gap    <= cfg_wdata_i[c39_pkg::GapW-1:0];
        c39_pkg::CfgLight:  cfg_q.light  <= cfg_wdata_i;
        c39_pkg::CfgDark:   cfg_q.dark   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  c39_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_job_o       (push_job)
  );

  c39_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wr_job_i (push_job),
    .pop_i    (q_pop),
    .rd_job_o (head_job),
    .full_o   (q_full),
    .empty_o  (q_empty)
  );

  c39_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_job_i       (head_job),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> verif/code39_bar_run_generator_core_test.sv
// ----------------------------------------------------------------------------
// code39_bar_run_generator_core_test
// Self-checking bench for the Code 39 bar run generator. Characters go in on
// the slave stream in bursts with random gaps, and the master stream stalls on
// a changing pattern of its own. Every accepted character is expanded into its
// expected bar runs: quiet zones, start and stop symbols, gaps, element widths
// and pixel values. Each run that leaves the block is compared field by field
// with the oldest expected run. A directed table covers the edge characters
// and flag combinations. Random lines then follow under several register
// settings, all-zero and all-ones among them.
// ----------------------------------------------------------------------------
module code39_bar_run_generator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] pix;
    logic [11:0] len;
    logic        eob;
  } bar_run_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_first;
    logic       is_last;
    logic       typed;
    logic [8:0] bars;
  } probe_t;

  typedef enum int {SinkOpen, SinkCoin, SinkSparse, SinkBeat} sink_mode_e;

  localparam logic [8:0] BarsStar  = 9'b010010100;
  localparam logic [8:0] BarsSpace = 9'b011000100;
  localparam logic [8:0] BarsDash  = 9'b010000101;
  localparam int ProbeCount = 25;

  localparam probe_t Probes [ProbeCount] = '{
    '{8'h2A, 1'b1, 1'b1, 1'b1, BarsStar},
    '{8'h00, 1'b1, 1'b0, 1'b1, BarsSpace},
    '{"a",   1'b0, 1'b0, 1'b0, 9'b0},
    '{"z",   1'b0, 1'b0, 1'b0, 9'b0},
    '{8'h60, 1'b0, 1'b0, 1'b1, BarsSpace},
    '{8'h7B, 1'b0, 1'b0, 1'b1, BarsSpace},
    '{8'h40, 1'b0, 1'b0, 1'b1, BarsSpace},
    '{8'h2D, 1'b0, 1'b0, 1'b1, BarsDash},
    '{8'h7C, 1'b0, 1'b0, 1'b1, BarsDash},
    '{8'h7F, 1'b0, 1'b0, 1'b1, BarsSpace},
    '{8'h80, 1'b0, 1'b0, 1'b1, BarsSpace},
    '{8'hFF, 1'b0, 1'b0, 1'b1, BarsSpace},
    '{8'h20, 1'b0, 1'b0, 1'b1, BarsSpace},
    '{"$",   1'b0, 1'b0, 1'b0, 9'b0},
    '{"%",   1'b0, 1'b0, 1'b0, 9'b0},
    '{"+",   1'b0, 1'b0, 1'b0, 9'b0},
    '{".",   1'b0, 1'b0, 1'b0, 9'b0},
    '{"/",   1'b0, 1'b0, 1'b0, 9'b0},
    '{"0",   1'b0, 1'b0, 1'b0, 9'b0},
    '{"9",   1'b0, 1'b0, 1'b0, 9'b0},
    '{"A",   1'b0, 1'b0, 1'b0, 9'b0},
    '{"Z",   1'b0, 1'b1, 1'b0, 9'b0},
    '{"Q",   1'b0, 1'b1, 1'b0, 9'b0},
    '{"M",   1'b1, 1'b0, 1'b0, 9'b0},
    '{"K",   1'b1, 1'b1, 1'b0, 9'b0}
  };

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic [c39_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [c39_pkg::CfgW-1:0]     cfg_wdata_i   = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [c39_pkg::CharW-1:0]    s_axis_tdata  = '0;
  logic                         s_axis_tuser  = 1'b0;
  logic                         s_axis_tlast  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [c39_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tlast;

  logic [11:0] margin_w = 12'd200;
  logic [7:0]  narrow_w = 8'd8;
  logic [9:0]  wide_w   = 10'd16;
  logic [7:0]  gap_w    = 8'd8;
  logic [15:0] light_px = 16'd4095;
  logic [15:0] dark_px  = 16'd0;

  bar_run_t runs_q[$];
  int       fail_count = 0;
  int       burst_left = 0;
  string    glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-. $/+%|*";

  code39_bar_run_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [8:0] code39_bars(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (up)
      "$": return 9'b010101000;
      "%": return 9'b000101010;
      "*": return BarsStar;
      "+": return 9'b010001010;
      "|": return BarsDash;
      "-": return BarsDash;
      ".": return 9'b110000100;
      "/": return 9'b010100010;
      "0": return 9'b000110100;
      "1": return 9'b100100001;
      "2": return 9'b001100001;
      "3": return 9'b101100000;
      "4": return 9'b000110001;
      "5": return 9'b100110000;
      "6": return 9'b001110000;
      "7": return 9'b000100101;
      "8": return 9'b100100100;
      "9": return 9'b001100100;
      "A": return 9'b100001001;
      "B": return 9'b001001001;
      "C": return 9'b101001000;
      "D": return 9'b000011001;
      "E": return 9'b100011000;
      "F": return 9'b001011000;
      "G": return 9'b000001101;
      "H": return 9'b100001100;
      "I": return 9'b001001100;
      "J": return 9'b000011100;
      "K": return 9'b100000011;
      "L": return 9'b001000011;
      "M": return 9'b101000010;
      "N": return 9'b000010011;
      "O": return 9'b100010010;
      "P": return 9'b001010010;
      "Q": return 9'b000000111;
      "R": return 9'b100000110;
      "S": return 9'b001000110;
      "T": return 9'b000010110;
      "U": return 9'b110000001;
      "V": return 9'b011000001;
      "W": return 9'b111000000;
      "X": return 9'b010010001;
      "Y": return 9'b110010000;
      "Z": return 9'b011010000;
      default: return BarsSpace;
    endcase
  endfunction

  task automatic add_run(input logic [15:0] pix, input logic [11:0] len);
    runs_q.push_back(bar_run_t'{pix, len, 1'b0});
  endtask

  // element 0 is the leftmost bit and always dark
  task automatic add_symbol(input logic [8:0] bars);
    for (int n = 0; n < 9; n++) begin
      add_run(n[0] ? light_px : dark_px, bars[8-n] ? {2'b0, wide_w} : {4'b0, narrow_w});
    end
  endtask

  task automatic expand_char(input logic [8:0] bars, input logic is_first, input logic is_last);
    if (is_first) begin
      add_run(light_px, margin_w);
      add_symbol(BarsStar);
      add_run(light_px, {4'b0, gap_w});
    end
    add_symbol(bars);
    add_run(light_px, {4'b0, gap_w});
    if (is_last) begin
      add_symbol(BarsStar);
      add_run(light_px, margin_w);
    end
    runs_q[runs_q.size()-1].eob = 1'b1;
  endtask

  task automatic send_char(input logic [7:0] ch, input logic is_first, input logic is_last,
                           input logic [8:0] bars);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= is_first;
    s_axis_tlast  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expand_char(bars, is_first, is_last);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [c39_pkg::CfgIdxW-1:0] idx,
                           input logic [c39_pkg::CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      c39_pkg::CfgMargin: margin_w = val[11:0];
      c39_pkg::CfgNarrow: narrow_w = val[7:0];
      c39_pkg::CfgWide:   wide_w   = val[9:0];
      c39_pkg::CfgGap:    gap_w    = val[7:0];
      c39_pkg::CfgLight:  light_px = val;
      c39_pkg::CfgDark:   dark_px  = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [15:0] margin, input logic [15:0] narrow,
                           input logic [15:0] wide, input logic [15:0] gap,
                           input logic [15:0] light, input logic [15:0] dark);
    write_reg(c39_pkg::CfgMargin, margin);
    write_reg(c39_pkg::CfgNarrow, narrow);
    write_reg(c39_pkg::CfgWide, wide);
    write_reg(c39_pkg::CfgGap, gap);
    write_reg(c39_pkg::CfgLight, light);
    write_reg(c39_pkg::CfgDark, dark);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (runs_q.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) != 0) begin
      return glyphs[$urandom_range(0, glyphs.len() - 1)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly whole lines, the rest loose characters with random flags
  task automatic random_lines(input int count);
    int left;
    int span;
    logic [7:0] ch;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 4) != 0) begin
        span = $urandom_range(1, 8);
        if (span > left) span = left;
        for (int i = 0; i < span; i++) begin
          ch = pick_char();
          send_char(ch, i == 0, i == span - 1, code39_bars(ch));
        end
      end else begin
        span = 1;
        ch = 8'($urandom_range(0, 255));
        send_char(ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), code39_bars(ch));
      end
      left -= span;
    end
  endtask

  initial begin
    sink_mode_e mode;
    int span;
    int beat;
    beat = 0;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk_i);
        beat++;
        case (mode)
          SinkOpen:   m_axis_tready <= 1'b1;
          SinkCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
          SinkSparse: m_axis_tready <= ($urandom_range(0, 5) == 0);
          default:    m_axis_tready <= (beat % 4 != 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    bar_run_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (runs_q.size() == 0) begin
        $display("%0t: unexpected run, got pix %h len %0d last %b pad %h", $time,
                 m_axis_tdata[15:0], m_axis_tdata[27:16], m_axis_tlast, m_axis_tdata[31:28]);
        fail_count++;
      end else begin
        want = runs_q.pop_front();
        if (m_axis_tdata[15:0] !== want.pix || m_axis_tdata[27:16] !== want.len ||
            m_axis_tlast !== want.eob || m_axis_tdata[31:28] !== 4'b0) begin
          $display("%0t: mismatch, exp pix %h len %0d last %b, got pix %h len %0d last %b pad %h",
                   $time, want.pix, want.len, want.eob,
                   m_axis_tdata[15:0], m_axis_tdata[27:16], m_axis_tlast, m_axis_tdata[31:28]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    probe_t p;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    for (int i = 0; i < ProbeCount; i++) begin
      p = Probes[i];
      send_char(p.ch, p.is_first, p.is_last, p.typed ? p.bars : code39_bars(p.ch));
    end
    random_lines(50);
    settle();

    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_lines(45);
    settle();

    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_lines(45);
    settle();

    configure(16'd12, 16'd1, 16'd3, 16'd2, 16'hFFFF, 16'h0000);
    random_lines(50);
    settle();

    repeat (3) begin
      configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      random_lines(50);
      settle();
    end

    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> code39_bar_run_generator_core.f
rtl/core/c39_pkg.sv
rtl/core/c39_front.sv
rtl/core/c39_fifo.sv
rtl/core/c39_back.sv
rtl/core/code39_bar_run_generator_core.sv
verif/code39_bar_run_generator_core_test.sv
